// File: rtl/core/owbm_pkg.sv
// Package for the single-wire bus master: payload structs, command and
// phase codes, register indexes and reset values. No dependencies.
package owbm_pkg;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] write_byte;
    logic       line_level;
  } owbm_in_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence_ok;
    logic [7:0] read_byte;
  } owbm_out_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] write_byte;
    logic       line_level;
  } owbm_item_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_RST_REL   = 4'd2,
    PH_PRES_LOW  = 4'd3,
    PH_PRES_HIGH = 4'd4,
    PH_RECOVER   = 4'd5,
    PH_WR_LOW    = 4'd6,
    PH_WR_HIGH   = 4'd7,
    PH_RD_LOW    = 4'd8,
    PH_RD_REL    = 4'd9,
    PH_RD_TAIL   = 4'd10
  } phase_e;

  typedef enum logic [2:0] {
    CFG_RESET_LOW   = 3'd0,
    CFG_PRES_LOW    = 3'd1,
    CFG_PRES_HIGH   = 3'd2,
    CFG_WR1_LOW     = 3'd3,
    CFG_WR1_HIGH    = 3'd4,
    CFG_WR0_LOW     = 3'd5,
    CFG_RD_LOW      = 3'd6,
    CFG_RD_TAIL     = 3'd7
  } cfg_idx_e;

  localparam int unsigned CfgW = 10;

  localparam logic [CfgW-1:0] RstLowReset   = 10'd500;
  localparam logic [CfgW-1:0] PresLowReset  = 10'd50;
  localparam logic [CfgW-1:0] PresHighReset = 10'd250;
  localparam logic [CfgW-1:0] Wr1LowReset   = 10'd8;
  localparam logic [CfgW-1:0] Wr1HighReset  = 10'd80;
  localparam logic [CfgW-1:0] Wr0LowReset   = 10'd80;
  localparam logic [CfgW-1:0] RdLowReset    = 10'd2;
  localparam logic [CfgW-1:0] RdTailReset   = 10'd70;

  localparam logic [CfgW-1:0] RecoveryTicks = 10'd10;
  localparam logic [CfgW-1:0] Wr0HighTicks  = 10'd5;
  localparam logic [CfgW-1:0] OneTick       = 10'd1;

endpackage

// File: rtl/core/owbm_front.sv
// Front end: accepts input transfers, decodes the command kind and holds
// items in a two-entry queue for the engine. Depends on owbm_pkg.
module owbm_front import owbm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  owbm_in_t   in_data_i,
  output logic       item_valid_o,
  output owbm_item_t item_o,
  input  logic       item_pop_i
);

  owbm_item_t  slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;
  owbm_item_t  item_new;

  always_comb begin
    item_new.write_byte = in_data_i.write_byte;
    item_new.line_level = in_data_i.line_level;
    case (cmd_e'(in_data_i.kind))
      CMD_RESET: item_new.cmd = CMD_RESET;
      CMD_WRITE: item_new.cmd = CMD_WRITE;
      CMD_READ:  item_new.cmd = CMD_READ;
      default:   item_new.cmd = CMD_NONE;
    endcase
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = slot_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_pop_i && item_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_new;
    end
  end

endmodule

// File: rtl/core/owbm_back.sv
// Back end: timing registers, the slot engine advanced once per item and
// the output register. Depends on owbm_pkg.
module owbm_back import owbm_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  cfg_idx_e        cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            item_valid_i,
  input  owbm_item_t      item_i,
  output logic            item_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output owbm_out_t       out_data_o
);

  localparam int unsigned LW = (COUNT_WIDTH > CfgW) ? COUNT_WIDTH : CfgW;
  localparam logic [LW-1:0] CntMax = LW'({COUNT_WIDTH{1'b1}});

  logic [CfgW-1:0] rst_low_q, pres_low_q, pres_high_q, wr1_low_q;
  logic [CfgW-1:0] wr1_high_q, wr0_low_q, rd_low_q, rd_tail_q;

  phase_e                 phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] tick_q, tick_d;
  logic [2:0]             bit_q, bit_d;
  logic [7:0]             shift_q, shift_d;
  logic                   pres_q, pres_d;
  logic                   cur_q, cur_d;
  logic [7:0]             rd_res_q, rd_res_d;

  logic      out_valid_q;
  owbm_out_t out_q, out_d;
  logic      step;

  assign step        = item_valid_i && (!out_valid_q || out_ready_i);
  assign item_pop_o  = step;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rst_low_q   <= RstLowReset;
      pres_low_q  <= PresLowReset;
      pres_high_q <= PresHighReset;
      wr1_low_q   <= Wr1LowReset;
      wr1_high_q  <= Wr1HighReset;
      wr0_low_q   <= Wr0LowReset;
      rd_low_q    <= RdLowReset;
      rd_tail_q   <= RdTailReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RESET_LOW: rst_low_q   <= cfg_data_i;
        CFG_PRES_LOW:  pres_low_q  <= cfg_data_i;
        CFG_PRES_HIGH: pres_high_q <= cfg_data_i;
        CFG_WR1_LOW:   wr1_low_q   <= cfg_data_i;
        CFG_WR1_HIGH:  wr1_high_q  <= cfg_data_i;
        CFG_WR0_LOW:   wr0_low_q   <= cfg_data_i;
        CFG_RD_LOW:    rd_low_q    <= cfg_data_i;
        CFG_RD_TAIL:   rd_tail_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_e                 ph;
    logic [COUNT_WIDTH-1:0] tk;
    logic [CfgW-1:0]        dur;
    logic [LW-1:0]          lim;
    logic                   expd;
    logic                   counting;
    logic                   drive;
    logic                   done;

    ph       = phase_q;
    tk       = tick_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    pres_d   = pres_q;
    cur_d    = cur_q;
    rd_res_d = rd_res_q;
    drive    = 1'b0;
    done     = 1'b0;
    counting = 1'b0;
    dur      = OneTick;

    if (phase_q == PH_IDLE && item_i.cmd != CMD_NONE) begin
      bit_d = 3'd0;
      tk    = '0;
      case (item_i.cmd)
        CMD_RESET: ph = PH_RST_LOW;
        CMD_WRITE: begin
          shift_d = item_i.write_byte;
          cur_d   = item_i.write_byte[0];
          ph      = PH_WR_LOW;
        end
        default: begin
          shift_d = 8'd0;
          ph      = PH_RD_LOW;
        end
      endcase
    end

    case (ph)
      PH_RST_LOW:   dur = rst_low_q;
      PH_PRES_LOW:  dur = pres_low_q;
      PH_PRES_HIGH: dur = pres_high_q;
      PH_RECOVER:   dur = RecoveryTicks;
      PH_WR_LOW:    dur = cur_d ? wr1_low_q : wr0_low_q;
      PH_WR_HIGH:   dur = cur_d ? wr1_high_q : Wr0HighTicks;
      PH_RD_LOW:    dur = rd_low_q;
      PH_RD_TAIL:   dur = rd_tail_q;
      default:      dur = OneTick;
    endcase
    lim = (dur == '0) ? LW'(1) : LW'(dur);
    if (lim > CntMax) begin
      lim = CntMax;
    end
    expd = ({1'b0, LW'(tk)} + (LW + 1)'(1)) >= {1'b0, lim};

    phase_d = ph;
    tick_d  = tk;

    case (ph)
      PH_IDLE: ;
      PH_RST_LOW: begin
        drive    = 1'b1;
        counting = 1'b1;
        if (expd) phase_d = PH_RST_REL;
      end
      PH_RST_REL: begin
        counting = 1'b1;
        if (expd) phase_d = PH_PRES_LOW;
      end
      PH_PRES_LOW: begin
        if (!item_i.line_level) begin
          phase_d = PH_PRES_HIGH;
        end else begin
          counting = 1'b1;
          if (expd) begin
            pres_d  = 1'b0;
            done    = 1'b1;
            phase_d = PH_IDLE;
          end
        end
      end
      PH_PRES_HIGH: begin
        if (item_i.line_level) begin
          phase_d = PH_RECOVER;
        end else begin
          counting = 1'b1;
          if (expd) begin
            pres_d  = 1'b0;
            done    = 1'b1;
            phase_d = PH_IDLE;
          end
        end
      end
      PH_RECOVER: begin
        counting = 1'b1;
        if (expd) begin
          pres_d  = 1'b1;
          done    = 1'b1;
          phase_d = PH_IDLE;
        end
      end
      PH_WR_LOW: begin
        drive    = 1'b1;
        counting = 1'b1;
        if (expd) phase_d = PH_WR_HIGH;
      end
      PH_WR_HIGH: begin
        counting = 1'b1;
        if (expd) begin
          shift_d = {1'b0, shift_d[7:1]};
          if (bit_d == 3'd7) begin
            done    = 1'b1;
            phase_d = PH_IDLE;
          end else begin
            bit_d   = bit_d + 3'd1;
            cur_d   = shift_d[0];
            phase_d = PH_WR_LOW;
          end
        end
      end
      PH_RD_LOW: begin
        drive    = 1'b1;
        counting = 1'b1;
        if (expd) phase_d = PH_RD_REL;
      end
      PH_RD_REL: begin
        counting = 1'b1;
        if (expd) phase_d = PH_RD_TAIL;
      end
      PH_RD_TAIL: begin
        if (tk == '0) begin
          shift_d = {item_i.line_level, shift_d[7:1]};
        end
        counting = 1'b1;
        if (expd) begin
          if (bit_d == 3'd7) begin
            rd_res_d = shift_d;
            done     = 1'b1;
            phase_d  = PH_IDLE;
          end else begin
            bit_d   = bit_d + 3'd1;
            phase_d = PH_RD_LOW;
          end
        end
      end
      default: phase_d = PH_IDLE;
    endcase

    if (phase_d != ph) begin
      tick_d = '0;
    end else if (counting && !expd) begin
      tick_d = tk + COUNT_WIDTH'(1);
    end

    out_d.drive_low   = drive;
    out_d.busy_res    = (phase_d != PH_IDLE);
    out_d.done_res    = done;
    out_d.presence_ok = pres_d;
    out_d.read_byte   = rd_res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      bit_q       <= 3'd0;
      shift_q     <= 8'd0;
      pres_q      <= 1'b0;
      cur_q       <= 1'b0;
      rd_res_q    <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        phase_q  <= phase_d;
        tick_q   <= tick_d;
        bit_q    <= bit_d;
        shift_q  <= shift_d;
        pres_q   <= pres_d;
        cur_q    <= cur_d;
        rd_res_q <= rd_res_d;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= out_d;
    end
  end

endmodule

// File: rtl/core/one_wire_bus_master.sv
// Single-wire bus master top level: front queue plus slot engine.
// Path: an input is held in the front queue, then stepped through the
// engine into the output register, from which it transfers.
// Throughput: one item per cycle while the output is not stalled; the engine
// steps once per item, through a two-entry queue and a registered output.
// Reset: asynchronous, active low; idle, timing registers at defaults.
// Depends on owbm_pkg, owbm_front, owbm_back.
module one_wire_bus_master import owbm_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  owbm_in_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output owbm_out_t       out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [2:0]      cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  logic       item_valid;
  owbm_item_t item;
  logic       item_pop;

  assign cfg_ready_o = 1'b1;

  owbm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  owbm_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_idx_i    (cfg_idx_e'(cfg_index_i)),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
